// ===== rtl/text_cell_glyph_renderer_assert.svh =====
// ----------------------------------------------------------------------------
// text_cell_glyph_renderer_assert
// Assertion macros used by the glyph renderer back end (tcgr_back).
// Each macro expects clk and rst_n in scope.
// ----------------------------------------------------------------------------
`ifndef TEXT_CELL_GLYPH_RENDERER_ASSERT_SVH
`define TEXT_CELL_GLYPH_RENDERER_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define TCGR_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define TCGR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/tcgr_pkg.sv =====
// ----------------------------------------------------------------------------
// tcgr_pkg
// Types, palette and constants of the text cell glyph renderer.
// ----------------------------------------------------------------------------
package tcgr_pkg;

  localparam int unsigned STRIDE_W    = 13;
  localparam int unsigned OFFSET_W    = 22;
  localparam int unsigned QUEUE_DEPTH = 2;

  localparam logic [STRIDE_W-1:0] STRIDE_RESET = 13'd1280;
  localparam logic [15:0]         ROW_ALL_ON   = 16'hFFFF;
  localparam logic [3:0]          ROW_UNDERLINE = 4'd15;
  localparam logic [3:0]          ROW_STRIKE    = 4'd7;
  localparam logic [3:0]          ROW_LAST      = 4'd15;
  localparam logic [1:0]          GRP_LAST      = 2'd3;

  localparam logic ACT_DRAW = 1'b0;
  localparam logic ACT_LOAD = 1'b1;

  // attribute bit positions
  localparam int unsigned ATTR_BOLD      = 0;
  localparam int unsigned ATTR_FAINT     = 1;
  localparam int unsigned ATTR_REVERSE   = 2;
  localparam int unsigned ATTR_UNDERLINE = 3;
  localparam int unsigned ATTR_STRIKE    = 4;

  typedef struct packed {
    logic        action;
    logic [7:0]  char_code;
    logic [6:0]  cell_column;
    logic [5:0]  cell_row;
    logic [2:0]  fg_index;
    logic [2:0]  bg_index;
    logic [4:0]  attributes;
    logic [3:0]  glyph_row;
    logic [15:0] glyph_bits;
  } in_item_t;

  typedef struct packed {
    logic [OFFSET_W-1:0] pixel_offset;
    logic [63:0]         pixel_data;
    logic                last;
  } out_item_t;

  // classified command passed from front to back
  typedef struct packed {
    logic                is_load;
    logic                glyph_ok;
    logic [7:0]          char_code;
    logic [3:0]          glyph_row;
    logic [15:0]         glyph_bits;
    logic [OFFSET_W-1:0] base_offset;
    logic [15:0]         fg_color;
    logic [15:0]         bg_color;
    logic                underline;
    logic                strike;
  } cmd_t;

  typedef struct packed {
    logic push;
    cmd_t cmd;
  } q_wr_t;

  typedef struct packed {
    logic nonempty;
    logic full;
    cmd_t head;
  } q_rd_t;

  typedef enum logic [0:0] {
    S_IDLE,
    S_EMIT
  } back_state_t;

  function automatic logic [15:0] palette(input logic [4:0] idx);
    logic [15:0] c;
    case (idx)
      5'd0:    c = 16'h0000;
      5'd1:    c = 16'h8000;
      5'd2:    c = 16'h0400;
      5'd3:    c = 16'h8400;
      5'd4:    c = 16'h0010;
      5'd5:    c = 16'h8010;
      5'd6:    c = 16'h0410;
      5'd7:    c = 16'hC618;
      5'd8:    c = 16'h8410;
      5'd9:    c = 16'hF800;
      5'd10:   c = 16'h07E0;
      5'd11:   c = 16'hFFE0;
      5'd12:   c = 16'h001F;
      5'd13:   c = 16'hF81F;
      5'd14:   c = 16'h07FF;
      5'd15:   c = 16'hFFFF;
      5'd16:   c = 16'h0000;
      5'd17:   c = 16'h4000;
      5'd18:   c = 16'h0200;
      5'd19:   c = 16'h4200;
      5'd20:   c = 16'h0008;
      5'd21:   c = 16'h4008;
      5'd22:   c = 16'h0208;
      5'd23:   c = 16'h630C;
      default: c = 16'h0000;
    endcase
    return c;
  endfunction

endpackage

// ===== rtl/text_cell_glyph_renderer.sv =====
// ----------------------------------------------------------------------------
// text_cell_glyph_renderer
// Renders 16x16 text cells into RGB565 pixel groups from a glyph store.
// ----------------------------------------------------------------------------
//  channel | handshake          | payload
//  --------+--------------------+-----------------------------------
//  in      | in_valid/in_stall  | in_item  (draw or glyph row load)
//  out     | out_valid/out_stall| out_item (offset, 4 pixels, last)
//  cfg     | cfg_valid/cfg_ready| cfg_data (line stride)
//
//  A draw occupies the back end for one glyph store read, then one item per
//  cycle, the next row read overlapping the last group of each row. A load
//  is written straight from the queue head. A two-entry queue lets the front
//  accept while a draw runs. Output stalls freeze the draw in place.
//  Reset (synchronous, rst_n low) clears control state and sets the stride to
//  1280; glyph contents are undefined until loaded.
module text_cell_glyph_renderer import tcgr_pkg::*; #(
  parameter int unsigned GLYPH_COUNT = 256
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  in_item_t            in_item,
  output logic                out_valid,
  input  logic                out_stall,
  output out_item_t           out_item,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [STRIDE_W-1:0] cfg_data
);

  q_wr_t               q_wr;
  q_rd_t               q_rd;
  logic                q_pop;
  logic [STRIDE_W-1:0] stride;

  tcgr_front #(
    .GLYPH_COUNT (GLYPH_COUNT)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .stride    (stride),
    .q_rd      (q_rd),
    .q_wr      (q_wr)
  );

  tcgr_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .q_wr  (q_wr),
    .pop   (q_pop),
    .q_rd  (q_rd)
  );

  tcgr_back #(
    .GLYPH_COUNT (GLYPH_COUNT)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .stride    (stride),
    .q_rd      (q_rd),
    .pop       (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

endmodule

// ===== rtl/tcgr_front.sv =====
// ----------------------------------------------------------------------------
// tcgr_front
// Accepts items, resolves colors and the cell base offset, feeds the queue.
// ----------------------------------------------------------------------------
module tcgr_front import tcgr_pkg::*; #(
  parameter int unsigned GLYPH_COUNT = 256
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  in_item_t            in_item,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [STRIDE_W-1:0] cfg_data,
  output logic [STRIDE_W-1:0] stride,
  input  q_rd_t               q_rd,
  output q_wr_t               q_wr
);

  logic [STRIDE_W-1:0] stride_r, stride_nxt;
  logic [4:0]          fg_sel, bg_sel, fg_adj;
  logic [9:0]          line0;
  logic [22:0]         line_prod;
  logic [OFFSET_W-1:0] col_off;
  logic                code_ok;

  assign cfg_ready = 1'b1;
  assign stride    = stride_r;
  assign stride_nxt = (cfg_valid && cfg_ready) ? cfg_data : stride_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stride_r <= STRIDE_RESET;
    end else begin
      stride_r <= stride_nxt;
    end
  end

  assign in_stall = q_rd.full;

  assign code_ok = {3'b000, in_item.char_code} < 11'(GLYPH_COUNT);

  always_comb begin
    fg_adj = {2'b00, in_item.fg_index};
    if (in_item.attributes[ATTR_BOLD]) begin
      fg_adj = fg_adj + 5'd8;
    end else if (in_item.attributes[ATTR_FAINT]) begin
      fg_adj = fg_adj + 5'd16;
    end
    if (in_item.attributes[ATTR_REVERSE]) begin
      fg_sel = {2'b00, in_item.bg_index};
      bg_sel = fg_adj;
    end else begin
      fg_sel = fg_adj;
      bg_sel = {2'b00, in_item.bg_index};
    end
  end

  // first line of the cell times stride, plus the cell's left column
  assign line0     = {in_item.cell_row, 4'b0000};
  assign line_prod = 23'(stride_r) * 23'(line0);
  assign col_off   = OFFSET_W'({in_item.cell_column, 4'b0000});

  always_comb begin
    q_wr.push             = in_valid && !in_stall;
    q_wr.cmd.is_load      = (in_item.action == ACT_LOAD);
    q_wr.cmd.glyph_ok     = code_ok;
    q_wr.cmd.char_code    = in_item.char_code;
    q_wr.cmd.glyph_row    = in_item.glyph_row;
    q_wr.cmd.glyph_bits   = in_item.glyph_bits;
    q_wr.cmd.base_offset  = line_prod[OFFSET_W-1:0] + col_off;
    q_wr.cmd.fg_color     = palette(fg_sel);
    q_wr.cmd.bg_color     = palette(bg_sel);
    q_wr.cmd.underline    = in_item.attributes[ATTR_UNDERLINE];
    q_wr.cmd.strike       = in_item.attributes[ATTR_STRIKE];
  end

endmodule

// ===== rtl/tcgr_queue.sv =====
// ----------------------------------------------------------------------------
// tcgr_queue
// Short command queue between front and back.
// ----------------------------------------------------------------------------
module tcgr_queue import tcgr_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  q_wr_t q_wr,
  input  logic  pop,
  output q_rd_t q_rd
);

  localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

  cmd_t             slot_r [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             do_push, do_pop;

  assign do_push = q_wr.push && (count_r != CNT_W'(QUEUE_DEPTH));
  assign do_pop  = pop && (count_r != '0);

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    count_nxt = count_r + CNT_W'(do_push) - CNT_W'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= q_wr.cmd;
    end
  end

  assign q_rd.nonempty = (count_r != '0);
  assign q_rd.full     = (count_r == CNT_W'(QUEUE_DEPTH));
  assign q_rd.head     = slot_r[rd_ptr_r];

endmodule

// ===== rtl/tcgr_back.sv =====
// ----------------------------------------------------------------------------
// tcgr_back
// Executes commands: glyph row writes and 64-result cell draws.
// ----------------------------------------------------------------------------
module tcgr_back import tcgr_pkg::*; #(
  parameter int unsigned GLYPH_COUNT = 256
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic [STRIDE_W-1:0] stride,
  input  q_rd_t               q_rd,
  output logic                pop,
  output logic                out_valid,
  input  logic                out_stall,
  output out_item_t           out_item
);

  localparam int unsigned CODE_W = (GLYPH_COUNT > 1) ? $clog2(GLYPH_COUNT) : 1;
  localparam int unsigned ADDR_W = CODE_W + 4;
  localparam int unsigned DEPTH  = GLYPH_COUNT * 16;

  logic [15:0]         glyph_mem [DEPTH];
  logic [15:0]         rd_data_r;

  back_state_t         state_r, state_nxt;
  cmd_t                cmd_r, cmd_nxt;
  logic [3:0]          row_r, row_nxt;
  logic [1:0]          grp_r, grp_nxt;
  logic [OFFSET_W-1:0] row_off_r, row_off_nxt;
  logic                out_valid_r, out_valid_nxt;
  out_item_t           out_item_r, out_item_nxt;

  logic                out_free, out_load, rd_en, mem_we;
  logic [ADDR_W-1:0]   rd_addr, wr_addr;
  logic [15:0]         head_code_w, cur_code_w;
  logic [15:0]         row_bits;
  logic [3:0]          nib;
  logic                is_last;
  out_item_t           res;

  assign head_code_w = {8'h00, q_rd.head.char_code};
  assign cur_code_w  = {8'h00, cmd_r.char_code};
  assign wr_addr     = {head_code_w[CODE_W-1:0], q_rd.head.glyph_row};
  assign out_free    = !out_valid_r || !out_stall;
  assign is_last     = (row_r == ROW_LAST) && (grp_r == GRP_LAST);

  // glyph row with attribute overrides
  always_comb begin
    row_bits = cmd_r.glyph_ok ? rd_data_r : 16'h0000;
    if (cmd_r.underline && row_r == ROW_UNDERLINE) begin
      row_bits = ROW_ALL_ON;
    end
    if (cmd_r.strike && row_r == ROW_STRIKE) begin
      row_bits = ROW_ALL_ON;
    end
    case (grp_r)
      2'd0:    nib = row_bits[15:12];
      2'd1:    nib = row_bits[11:8];
      2'd2:    nib = row_bits[7:4];
      default: nib = row_bits[3:0];
    endcase
  end

  always_comb begin
    res.pixel_offset = row_off_r + OFFSET_W'({grp_r, 2'b00});
    for (int k = 0; k < 4; k++) begin
      res.pixel_data[16*k +: 16] = nib[3-k] ? cmd_r.fg_color : cmd_r.bg_color;
    end
    res.last = is_last;
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (q_rd.nonempty && !q_rd.head.is_load) begin
          state_nxt = S_EMIT;
        end
      end
      S_EMIT: begin
        if (out_free && is_last) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // outputs and datapath
  always_comb begin
    pop         = 1'b0;
    mem_we      = 1'b0;
    rd_en       = 1'b0;
    out_load    = 1'b0;
    rd_addr     = {head_code_w[CODE_W-1:0], 4'd0};
    cmd_nxt     = cmd_r;
    row_nxt     = row_r;
    grp_nxt     = grp_r;
    row_off_nxt = row_off_r;
    case (state_r)
      S_IDLE: begin
        if (q_rd.nonempty) begin
          pop = 1'b1;
          if (q_rd.head.is_load) begin
            mem_we = q_rd.head.glyph_ok;
          end else begin
            rd_en       = q_rd.head.glyph_ok;
            cmd_nxt     = q_rd.head;
            row_nxt     = '0;
            grp_nxt     = '0;
            row_off_nxt = q_rd.head.base_offset;
          end
        end
      end
      S_EMIT: begin
        out_load = out_free;
        rd_addr  = {cur_code_w[CODE_W-1:0], row_r + 4'd1};
        if (out_free) begin
          grp_nxt = grp_r + 2'd1;
          if (grp_r == GRP_LAST) begin
            row_nxt     = row_r + 4'd1;
            row_off_nxt = row_off_r + OFFSET_W'(stride);
            // fetch next row while the last group of this one goes out
            rd_en       = cmd_r.glyph_ok && (row_r != ROW_LAST);
          end
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_item_nxt  = out_item_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
      out_item_nxt  = res;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      row_r       <= '0;
      grp_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      row_r       <= row_nxt;
      grp_r       <= grp_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r      <= cmd_nxt;
    row_off_r  <= row_off_nxt;
    out_item_r <= out_item_nxt;
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      glyph_mem[wr_addr] <= q_rd.head.glyph_bits;
    end
    if (rd_en) begin
      rd_data_r <= glyph_mem[rd_addr];
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

`include "text_cell_glyph_renderer_assert.svh"

  `TCGR_ASSERT_NOW(a_pop_in_idle, pop, state_r == S_IDLE, "queue popped during a draw")
  `TCGR_ASSERT_NEXT(a_last_ends_draw, out_load && is_last, state_r == S_IDLE,
                    "draw did not end after its last item")
  `TCGR_ASSERT_NOW(a_next_row_fetch,
                   out_load && grp_r == GRP_LAST && row_r != ROW_LAST && cmd_r.glyph_ok,
                   rd_en, "next glyph row not fetched")

endmodule

// ===== tb/sv/text_cell_glyph_renderer_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// text_cell_glyph_renderer_tb
// Self-checking bench for the glyph renderer. Glyph rows are loaded, cells
// are drawn under several line strides and handshake pressure settings, and
// every four-pixel group is compared with a locally rendered expectation.
// ----------------------------------------------------------------------------
module text_cell_glyph_renderer_tb;
  import tcgr_pkg::*;

  localparam int CYCLE_LIMIT = 600000;
  localparam int SETTLE_CYCLES = 80;
  localparam int HOLD_CYCLES = 600;
  localparam int SHOWN_MISMATCHES = 10;

  typedef struct packed {
    logic     drain_first;
    in_item_t item;
  } cell_cmd_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  in_item_t in_item = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_item_t out_item;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [STRIDE_W-1:0] cfg_data = '0;

  text_cell_glyph_renderer dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  // bench copy of the block state
  logic [15:0] glyph_image [0:4095];
  logic [STRIDE_W-1:0] line_stride_now = STRIDE_RESET;

  // generator bookkeeping: which rows of each glyph have been queued for load
  logic [15:0] rows_loaded [0:255];
  logic [7:0] focus_codes [0:7];

  cell_cmd_t cell_cmds_to_send [$];
  out_item_t pixel_groups_due [$];
  cell_cmd_t next_cmd;

  int sender_idle_pct = 0;
  int receiver_stall_pct = 0;
  logic hold_kick = 1'b0;
  int hold_left = 0;
  int cycle_count = 0;
  int mismatches = 0;
  int groups_checked = 0;
  int loads_sent = 0;
  int draws_sent = 0;
  int stride_writes = 0;

  initial begin
    forever #2 clk = ~clk;
  end

  function automatic logic [15:0] pack565(input int unsigned r, input int unsigned g,
                                          input int unsigned b);
    return {r[7:3], g[7:2], b[7:3]};
  endfunction

  function automatic logic [15:0] shade(input logic [4:0] idx);
    case (idx)
      5'd0:    return pack565(0, 0, 0);
      5'd1:    return pack565(128, 0, 0);
      5'd2:    return pack565(0, 128, 0);
      5'd3:    return pack565(128, 128, 0);
      5'd4:    return pack565(0, 0, 128);
      5'd5:    return pack565(128, 0, 128);
      5'd6:    return pack565(0, 128, 128);
      5'd7:    return pack565(192, 192, 192);
      5'd8:    return pack565(128, 128, 128);
      5'd9:    return pack565(255, 0, 0);
      5'd10:   return pack565(0, 255, 0);
      5'd11:   return pack565(255, 255, 0);
      5'd12:   return pack565(0, 0, 255);
      5'd13:   return pack565(255, 0, 255);
      5'd14:   return pack565(0, 255, 255);
      5'd15:   return pack565(255, 255, 255);
      5'd16:   return pack565(0, 0, 0);
      5'd17:   return pack565(64, 0, 0);
      5'd18:   return pack565(0, 64, 0);
      5'd19:   return pack565(64, 64, 0);
      5'd20:   return pack565(0, 0, 64);
      5'd21:   return pack565(64, 0, 64);
      5'd22:   return pack565(0, 64, 64);
      5'd23:   return pack565(96, 96, 96);
      default: return 16'h0000;
    endcase
  endfunction

  task automatic render_cell(input in_item_t it);
    logic [15:0] rows [0:15];
    logic [4:0] fgi;
    logic [4:0] bgi;
    logic [4:0] swap;
    logic [15:0] fg;
    logic [15:0] bg;
    int unsigned x;
    int unsigned line;
    out_item_t grp;
    for (int r = 0; r < 16; r++) rows[r] = glyph_image[it.char_code * 16 + r];
    if (it.attributes[ATTR_UNDERLINE]) rows[ROW_UNDERLINE] = ROW_ALL_ON;
    if (it.attributes[ATTR_STRIKE]) rows[ROW_STRIKE] = ROW_ALL_ON;
    fgi = {2'b00, it.fg_index};
    bgi = {2'b00, it.bg_index};
    // bold takes precedence over faint
    if (it.attributes[ATTR_BOLD]) fgi = fgi + 5'd8;
    else if (it.attributes[ATTR_FAINT]) fgi = fgi + 5'd16;
    if (it.attributes[ATTR_REVERSE]) begin
      swap = fgi;
      fgi = bgi;
      bgi = swap;
    end
    fg = shade(fgi);
    bg = shade(bgi);
    for (int r = 0; r < 16; r++) begin
      line = it.cell_row * 16 + r;
      for (int g = 0; g < 4; g++) begin
        x = it.cell_column * 16 + 4 * g;
        grp.pixel_offset = OFFSET_W'(x + line_stride_now * line);
        for (int k = 0; k < 4; k++) begin
          grp.pixel_data[16*k +: 16] = rows[r][15 - (4 * g + k)] ? fg : bg;
        end
        grp.last = (r == 15 && g == 3);
        pixel_groups_due.push_back(grp);
      end
    end
  endtask

  task automatic apply_item(input in_item_t it);
    if (it.action == ACT_LOAD) begin
      glyph_image[it.char_code * 16 + it.glyph_row] = it.glyph_bits;
      loads_sent++;
    end else begin
      render_cell(it);
      draws_sent++;
    end
  endtask

  task automatic check_group(input out_item_t got);
    out_item_t want;
    if (pixel_groups_due.size() == 0) begin
      mismatches++;
      if (mismatches <= SHOWN_MISMATCHES)
        $display("unexpected pixel group: offset %h data %h last %b",
                 got.pixel_offset, got.pixel_data, got.last);
    end else begin
      want = pixel_groups_due.pop_front();
      groups_checked++;
      if (got.pixel_offset !== want.pixel_offset || got.pixel_data !== want.pixel_data ||
          got.last !== want.last) begin
        mismatches++;
        if (mismatches <= SHOWN_MISMATCHES)
          $display("group %0d mismatch: offset %h/%h data %h/%h last %b/%b (exp/got)",
                   groups_checked, want.pixel_offset, got.pixel_offset,
                   want.pixel_data, got.pixel_data, want.last, got.last);
      end
    end
  endtask

  // driver: hold the item while stalled, otherwise offer the next one or idle
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) apply_item(in_item);
      if (!in_valid || !in_stall) begin
        if (cell_cmds_to_send.size() != 0 &&
            !(cell_cmds_to_send[0].drain_first && pixel_groups_due.size() != 0) &&
            $urandom_range(99) >= sender_idle_pct) begin
          next_cmd = cell_cmds_to_send.pop_front();
          in_item <= next_cmd.item;
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // long receiver hold-off
  always @(posedge clk) begin
    if (hold_kick) hold_left <= HOLD_CYCLES;
    else if (hold_left != 0) hold_left <= hold_left - 1;
  end

  // monitor
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) check_group(out_item);
      out_stall <= (hold_left > 1) || ($urandom_range(99) < receiver_stall_pct);
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", CYCLE_LIMIT);
      $display("text_cell_glyph_renderer regression: fail");
      $finish;
    end
  end

  function automatic in_item_t filler();
    logic [63:0] raw;
    in_item_t it;
    raw = {$urandom, $urandom};
    it = raw[$bits(in_item_t)-1:0];
    return it;
  endfunction

  task automatic queue_load(input logic [7:0] code, input logic [3:0] row,
                            input logic [15:0] bits, input logic drain);
    cell_cmd_t c;
    c.item = filler();
    c.item.action = ACT_LOAD;
    c.item.char_code = code;
    c.item.glyph_row = row;
    c.item.glyph_bits = bits;
    c.drain_first = drain;
    rows_loaded[code][row] = 1'b1;
    cell_cmds_to_send.push_back(c);
  endtask

  task automatic queue_draw(input logic [7:0] code, input logic [6:0] col,
                            input logic [5:0] row, input logic [2:0] fg,
                            input logic [2:0] bg, input logic [4:0] attr,
                            input logic drain);
    cell_cmd_t c;
    c.item = filler();
    c.item.action = ACT_DRAW;
    c.item.char_code = code;
    c.item.cell_column = col;
    c.item.cell_row = row;
    c.item.fg_index = fg;
    c.item.bg_index = bg;
    c.item.attributes = attr;
    c.drain_first = drain;
    cell_cmds_to_send.push_back(c);
  endtask

  function automatic logic [15:0] random_bits();
    case ($urandom_range(7))
      0:       return 16'h0000;
      1:       return 16'hFFFF;
      default: return 16'($urandom);
    endcase
  endfunction

  // mostly draws of fully loaded glyphs; loads fill the focus glyphs row by row
  task automatic queue_random_items(input int count, input int drain_at);
    logic [7:0] ready_codes [$];
    logic [7:0] code;
    logic [3:0] row;
    logic drain;
    in_item_t r;
    for (int i = 0; i < count; i++) begin
      drain = (i == drain_at);
      ready_codes.delete();
      foreach (focus_codes[j])
        if (rows_loaded[focus_codes[j]] == 16'hFFFF) ready_codes.push_back(focus_codes[j]);
      if (ready_codes.size() != 0 && $urandom_range(99) < 70) begin
        r = filler();
        code = ready_codes[$urandom_range(ready_codes.size() - 1)];
        queue_draw(code, r.cell_column, r.cell_row, r.fg_index, r.bg_index, r.attributes,
                   drain);
      end else if ($urandom_range(99) < 60) begin
        code = focus_codes[$urandom_range(7)];
        row = 4'($urandom);
        for (int k = 15; k >= 0; k--) if (!rows_loaded[code][k]) row = 4'(k);
        queue_load(code, row, random_bits(), drain);
      end else begin
        queue_load(8'($urandom), 4'($urandom), random_bits(), drain);
      end
    end
  endtask

  task automatic wait_quiet();
    while (cell_cmds_to_send.size() != 0 || in_valid || pixel_groups_due.size() != 0)
      @(posedge clk);
    // trailing loads may still be in the block
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_line_stride(input logic [STRIDE_W-1:0] value);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= value;
    do @(posedge clk); while (!(cfg_valid && cfg_ready));
    cfg_valid <= 1'b0;
    line_stride_now = value;
    stride_writes++;
  endtask

  task automatic run_phase(input logic [STRIDE_W-1:0] stride, input int idle_pct,
                           input int stall_pct, input int count, input int drain_at);
    wait_quiet();
    set_line_stride(stride);
    sender_idle_pct = idle_pct;
    receiver_stall_pct = stall_pct;
    queue_random_items(count, drain_at);
  endtask

  initial begin
    for (int i = 0; i < 256; i++) rows_loaded[i] = '0;
    focus_codes[0] = 8'd0;
    focus_codes[1] = 8'd255;
    for (int i = 2; i < 8; i++) focus_codes[i] = 8'($urandom);

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // directed: glyph 0 with edge patterns, then every attribute path
    for (int r = 0; r < 16; r++) begin
      case (r % 6)
        0:       queue_load(8'd0, 4'(r), 16'h0000, 1'b0);
        1:       queue_load(8'd0, 4'(r), 16'hFFFF, 1'b0);
        2:       queue_load(8'd0, 4'(r), 16'h8001, 1'b0);
        3:       queue_load(8'd0, 4'(r), 16'hAAAA, 1'b0);
        4:       queue_load(8'd0, 4'(r), 16'h5555, 1'b0);
        default: queue_load(8'd0, 4'(r), 16'($urandom), 1'b0);
      endcase
    end
    queue_load(8'd255, 4'd15, 16'hFFFF, 1'b0);
    queue_draw(8'd0, 7'd0, 6'd0, 3'd0, 3'd7, 5'b00000, 1'b0);
    queue_draw(8'd0, 7'd127, 6'd63, 3'd7, 3'd0, 5'b11111, 1'b0);
    queue_draw(8'd0, 7'd5, 6'd9, 3'd7, 3'd1, 5'b00001, 1'b0);
    queue_draw(8'd0, 7'd64, 6'd32, 3'd7, 3'd2, 5'b00010, 1'b0);
    queue_draw(8'd0, 7'd1, 6'd1, 3'd3, 3'd5, 5'b00100, 1'b0);
    queue_draw(8'd0, 7'd2, 6'd62, 3'd6, 3'd4, 5'b01000, 1'b0);
    queue_draw(8'd0, 7'd126, 6'd2, 3'd1, 3'd6, 5'b10000, 1'b0);
    queue_draw(8'd0, 7'd100, 6'd40, 3'd7, 3'd0, 5'b00110, 1'b0);

    run_phase(13'($urandom_range(2, 4095)), 0, 0, 68, -1);
    run_phase(13'd1, 73, 0, 68, -1);
    run_phase(13'd4096, 0, 73, 68, -1);
    run_phase(13'd0, 16, 16, 68, -1);
    // receiver holds off while the sender keeps offering
    run_phase(13'd8191, 0, 0, 68, -1);
    hold_kick <= 1'b1;
    @(posedge clk);
    hold_kick <= 1'b0;
    // sender pauses midway until every pending group has drained
    run_phase(13'($urandom), 16, 16, 68, 34);

    while (cell_cmds_to_send.size() != 0 || in_valid || pixel_groups_due.size() != 0)
      @(posedge clk);
    repeat (100) @(posedge clk);

    $display("covered %0d glyph row loads and %0d cell draws over %0d stride settings,",
             loads_sent, draws_sent, stride_writes);
    $display("%0d pixel groups checked, %0d mismatches", groups_checked, mismatches);
    if (mismatches == 0 && pixel_groups_due.size() == 0) begin
      $display("text_cell_glyph_renderer regression: pass");
    end else begin
      $display("text_cell_glyph_renderer regression: fail");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/tcgr_pkg.sv
rtl/tcgr_front.sv
rtl/tcgr_queue.sv
rtl/tcgr_back.sv
rtl/text_cell_glyph_renderer.sv
tb/sv/text_cell_glyph_renderer_tb.sv
